[rtl/mctw_pkg.sv]
// types and constants shared by the multi-channel task watchdog
// no dependencies; compile first
package mctw_pkg;

	localparam int MAX_CH = 4;

	// input command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_BEAT  = 3'd1;
	localparam logic [2:0] CMD_PROG  = 3'd2;
	localparam logic [2:0] CMD_FAULT = 3'd3;
	localparam logic [2:0] CMD_CHECK = 3'd4;
	localparam logic [2:0] CMD_QUERY = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_REGISTERED = 3'd0;
	localparam logic [2:0] CFG_PERIODIC   = 3'd1;
	localparam logic [2:0] CFG_TIMEOUT0   = 3'd2;
	localparam logic [2:0] CFG_TIMEOUT1   = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT2   = 3'd4;
	localparam logic [2:0] CFG_TIMEOUT3   = 3'd5;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_BEAT,
		OP_PROG,
		OP_FAULT,
		OP_CHECK,
		OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		HS_UNKNOWN,
		HS_RUNNING,
		HS_RECOVERING,
		HS_DEGRADED
	} health_t;

	typedef enum logic {
		BK_IDLE,
		BK_CHECK
	} bk_state_t;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] channel;
		logic [3:0] recovery_ok_mask;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  report_channel;
		logic [1:0]  health_state;
		logic [15:0] fault_total;
		logic [7:0]  attempt_total;
		logic        timed_out;
		logic        stalled;
		logic        last;
	} rpt_item_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] channel;
		logic [3:0] ok_mask;
	} task_op_t;

	typedef struct packed {
		logic     valid;
		task_op_t op;
	} q_head_t;

	typedef struct packed {
		logic [3:0]             registered;
		logic [3:0]             periodic;
		logic [MAX_CH-1:0][15:0] timeout;
	} cfg_t;

endpackage

[rtl/mctw_stream_if.sv]
// valid/ready stream interface used for the command and report channels
// payload type set by the instantiating level
interface mctw_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/multi_channel_task_watchdog_unit.sv]
// top level of the multi-channel task watchdog: configuration registers, front and back ends
// depends on mctw_pkg, mctw_stream_if, mctw_front, mctw_back
//   cmd_in  (sink): one command per transfer: tick, heartbeat, progress, fault report,
//                   check or query, with a channel and a recovery mask
//   rpt_out (source): one report per transfer; a check gives one report per channel
//                   in ascending order with last set on the final one, fault and
//                   query give a single report with last set, other commands none
//   cfg_we/cfg_idx/cfg_data: register write port, taken on any clock edge with
//                   cfg_we high; indexes above five are dropped
// flow
//   a command is registered in the two-entry front queue before the back end takes
//   it; a check loads its mask, then walks one channel per cycle while rpt_out can
//   take a report; a fault or query is taken only when the report register is free,
//   and its report is registered as it is taken
// reset
//   arst_n clears all channel state, time, masks, queue pointers and report valid flag;
//   timeouts come up at 1000 ticks; there is no clearing pass
// stall
//   the report register holds while rpt_out.ready is low; the back end waits at a
//   check, fault or query, the queue fills and cmd_in.ready drops once two commands are waiting
module multi_channel_task_watchdog_unit #(
	parameter int NUM_CHANNELS = 4,
	parameter int TIME_WIDTH   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mctw_stream_if.sink          cmd_in,
	mctw_stream_if.source        rpt_out,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [15:0]          cfg_data
);
	import mctw_pkg::*;

	cfg_t    cfg_q;
	q_head_t head;
	logic    pop;
	logic [1:0] tsel;

	// timeout register select, only meaningful for timeout indexes
	assign tsel = 2'(cfg_idx - CFG_TIMEOUT0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.registered <= '0;
			cfg_q.periodic   <= '0;
			for (int i = 0; i < MAX_CH; i++) begin
				cfg_q.timeout[i] <= TIMEOUT_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_idx) inside
				CFG_REGISTERED: begin
					cfg_q.registered <= cfg_data[3:0];
				end
				CFG_PERIODIC: begin
					cfg_q.periodic <= cfg_data[3:0];
				end
				CFG_TIMEOUT0, CFG_TIMEOUT1, CFG_TIMEOUT2, CFG_TIMEOUT3: begin
					cfg_q.timeout[tsel] <= cfg_data;
				end
				default: begin
					cfg_q.registered <= cfg_q.registered;
				end
			endcase
		end
	end

	// front end: classify commands, drop unused codes and out-of-range channels of per-channel commands
	mctw_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_in.valid),
		.in_ready (cmd_in.ready),
		.in_data  (cmd_in.data),
		.head     (head),
		.pop      (pop)
	);

	// back end: channel state, check walk and report register
	mctw_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.pop       (pop),
		.out_valid (rpt_out.valid),
		.out_ready (rpt_out.ready),
		.out_data  (rpt_out.data)
	);
endmodule

[rtl/mctw_front.sv]
// front end: takes command transfers, classifies them and queues the ones that do work
// depends on mctw_pkg
module mctw_front #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mctw_pkg::cmd_item_t   in_data,
	output mctw_pkg::q_head_t     head,
	input  logic                  pop
);
	import mctw_pkg::*;

	task_op_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	task_op_t   op_d;
	logic       keep;
	logic       in_range;
	logic       push;
	logic       do_pop;

	assign in_range = {1'b0, in_data.channel} < 3'(NUM_CHANNELS);

	always_comb begin
		op_d.channel = in_data.channel;
		op_d.ok_mask = in_data.recovery_ok_mask;
		op_d.op      = OP_TICK;
		keep         = 1'b0;
		unique case (in_data.command)
			CMD_TICK: begin
				op_d.op = OP_TICK;
				keep    = 1'b1;
			end
			CMD_CHECK: begin
				op_d.op = OP_CHECK;
				keep    = 1'b1;
			end
			CMD_BEAT: begin
				op_d.op = OP_BEAT;
				keep    = in_range;
			end
			CMD_PROG: begin
				op_d.op = OP_PROG;
				keep    = in_range;
			end
			CMD_FAULT: begin
				op_d.op = OP_FAULT;
				keep    = in_range;
			end
			CMD_QUERY: begin
				op_d.op = OP_QUERY;
				keep    = in_range;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready && keep;
	assign head.valid = (count_q != 2'd0);
	assign head.op    = fifo_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

[rtl/mctw_back.sv]
// back end: holds the channel state, carries out queued operations and walks channels on check
// depends on mctw_pkg
module mctw_back #(
	parameter int NUM_CHANNELS = 4,
	parameter int TIME_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mctw_pkg::cfg_t        cfg,
	input  mctw_pkg::q_head_t     head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mctw_pkg::rpt_item_t   out_data
);
	import mctw_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

	bk_state_t            state_q, state_d;
	logic [IDX_W-1:0]     idx_q;
	logic [3:0]           ok_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [TIME_WIDTH-1:0] beat_q     [NUM_CHANNELS];
	logic [31:0]          prog_q     [NUM_CHANNELS];
	logic [31:0]          snap_q     [NUM_CHANNELS];
	health_t              health_q   [NUM_CHANNELS];
	logic [15:0]          faults_q   [NUM_CHANNELS];
	logic [7:0]           attempts_q [NUM_CHANNELS];
	rpt_item_t            rpt_q;
	logic                 out_valid_q;

	logic                 out_free;
	logic                 step;
	logic                 emit_single;
	logic [IDX_W-1:0]     sel;
	logic                 reg_bit;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                 to;
	logic                 st;
	logic [7:0]           att_inc;
	logic [15:0]          flt_inc;
	health_t              chk_health;
	logic [15:0]          chk_faults;
	logic [7:0]           chk_attempts;
	rpt_item_t            rpt_d;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && head.op.op == OP_CHECK) begin
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (out_free && idx_q == LAST_IDX) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop         = 1'b0;
		step        = 1'b0;
		emit_single = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					case (head.op.op) inside
						OP_FAULT, OP_QUERY: begin
							pop         = out_free;
							emit_single = out_free;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_CHECK: begin
				step = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign sel = (state_q == BK_CHECK) ? idx_q : head.op.channel[IDX_W-1:0];

	// health test of the selected channel
	assign reg_bit = cfg.registered[sel];
	assign elapsed = time_q - beat_q[sel];
	assign to      = reg_bit && (elapsed > TIME_WIDTH'(cfg.timeout[sel]));
	assign st      = reg_bit && cfg.periodic[sel] && (prog_q[sel] == snap_q[sel]);
	assign att_inc = (attempts_q[sel] == 8'hFF) ? attempts_q[sel] : attempts_q[sel] + 8'd1;
	assign flt_inc = (faults_q[sel] == 16'hFFFF) ? faults_q[sel] : faults_q[sel] + 16'd1;

	always_comb begin
		chk_health   = health_q[sel];
		chk_faults   = faults_q[sel];
		chk_attempts = attempts_q[sel];
		if (reg_bit) begin
			if (to || st) begin
				if (ok_q[sel]) begin
					chk_health   = HS_RUNNING;
					chk_attempts = 8'd0;
				end else begin
					chk_health   = HS_DEGRADED;
					chk_attempts = att_inc;
					chk_faults   = flt_inc;
				end
			end else begin
				chk_health = HS_RUNNING;
			end
		end
	end

	// result assembly
	always_comb begin
		rpt_d.report_channel = 2'(sel);
		rpt_d.health_state   = health_q[sel];
		rpt_d.fault_total    = faults_q[sel];
		rpt_d.attempt_total  = attempts_q[sel];
		rpt_d.timed_out      = 1'b0;
		rpt_d.stalled        = 1'b0;
		rpt_d.last           = 1'b1;
		if (step) begin
			rpt_d.health_state  = chk_health;
			rpt_d.fault_total   = chk_faults;
			rpt_d.attempt_total = chk_attempts;
			rpt_d.timed_out     = to;
			rpt_d.stalled       = st;
			rpt_d.last          = (idx_q == LAST_IDX);
		end else if (head.op.op == OP_FAULT) begin
			rpt_d.health_state = HS_DEGRADED;
			rpt_d.fault_total  = flt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			ok_q    <= '0;
			time_q  <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				beat_q[i]     <= '0;
				prog_q[i]     <= '0;
				snap_q[i]     <= '0;
				health_q[i]   <= HS_UNKNOWN;
				faults_q[i]   <= '0;
				attempts_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				case (head.op.op)
					OP_TICK: begin
						time_q <= time_q + TIME_WIDTH'(1);
					end
					OP_BEAT: begin
						beat_q[sel] <= time_q;
					end
					OP_PROG: begin
						prog_q[sel] <= prog_q[sel] + 32'd1;
					end
					OP_FAULT: begin
						faults_q[sel] <= flt_inc;
						health_q[sel] <= HS_DEGRADED;
					end
					OP_CHECK: begin
						idx_q <= '0;
						ok_q  <= head.op.ok_mask;
					end
					default: begin
						time_q <= time_q;
					end
				endcase
			end
			if (step) begin
				health_q[sel]   <= chk_health;
				faults_q[sel]   <= chk_faults;
				attempts_q[sel] <= chk_attempts;
				if (reg_bit) begin
					snap_q[sel] <= prog_q[sel];
				end
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step || emit_single) begin
			rpt_q <= rpt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step || emit_single) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = rpt_q;
endmodule

[tb/multi_channel_task_watchdog_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for multi_channel_task_watchdog_unit: directed table, random phases
// depends on mctw_pkg, mctw_stream_if and the unit's rtl; nothing else
module multi_channel_task_watchdog_unit_test;
	import mctw_pkg::*;

	localparam int CHANNELS     = 4;
	localparam int TIME_W       = 32;
	localparam int RESET_CYCLES = 11;
	// front queue plus a full channel walk, with margin
	localparam int DRAIN_CYCLES = 10;
	// cycles with no transfer on either side before the run is given up
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 80;
	localparam int PHASE_ITEMS  = 20;
	localparam int FAIL_CHECKS  = 6;

	// unused command codes and register indexes, both dropped by the unit
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;
	localparam logic [2:0] CFG_SPARE6 = 3'd6;
	localparam logic [2:0] CFG_SPARE7 = 3'd7;

	// one row of the directed table: a register write or a command,
	// the latter optionally with a report written out by hand
	typedef struct {
		bit        is_write;
		logic [2:0]  reg_idx;
		logic [15:0] reg_val;
		cmd_item_t cmd;
		bit        typed;
		rpt_item_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;

	mctw_stream_if #(.T(cmd_item_t)) cmd_bus ();
	mctw_stream_if #(.T(rpt_item_t)) rpt_bus ();

	multi_channel_task_watchdog_unit #(
		.NUM_CHANNELS(CHANNELS),
		.TIME_WIDTH(TIME_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_bus),
		.rpt_out(rpt_bus),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// watchdog state mirror: registers and per-channel bookkeeping
	// ---------------------------------------------------------------
	logic [3:0]        reg_mask;
	logic [3:0]        per_mask;
	logic [15:0]       ch_timeout [CHANNELS];
	logic [TIME_W-1:0] wd_time;
	logic [TIME_W-1:0] beat_time  [CHANNELS];
	logic [31:0]       prog_count [CHANNELS];
	logic [31:0]       prog_snap  [CHANNELS];
	health_t           ch_health  [CHANNELS];
	logic [15:0]       fault_cnt  [CHANNELS];
	logic [7:0]        attempt_cnt[CHANNELS];

	// reports still owed by the unit, oldest first
	rpt_item_t expected_reports[$];
	stim_row_t directed_rows[$];

	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	logic        steady;        // no random idling on either side
	logic        hold_request;  // ask the report side for one long stall

	function automatic rpt_item_t channel_report(int ch, bit late, bit stuck, bit fin);
		rpt_item_t r;
		r.report_channel = ch[1:0];
		r.health_state   = ch_health[ch];
		r.fault_total    = fault_cnt[ch];
		r.attempt_total  = attempt_cnt[ch];
		r.timed_out      = late;
		r.stalled        = stuck;
		r.last           = fin;
		return r;
	endfunction

	// advance the mirror by one accepted command and queue what it owes
	function automatic void predict_command(cmd_item_t c);
		logic [TIME_W-1:0] elapsed;
		bit late;
		bit stuck;
		case (c.command)
			CMD_TICK: wd_time = wd_time + TIME_W'(1);
			CMD_BEAT: beat_time[c.channel] = wd_time;
			CMD_PROG: prog_count[c.channel] = prog_count[c.channel] + 32'd1;
			CMD_FAULT: begin
				if (fault_cnt[c.channel] != 16'hFFFF)
					fault_cnt[c.channel]++;
				ch_health[c.channel] = HS_DEGRADED;
				expected_reports.push_back(channel_report(c.channel, 0, 0, 1));
			end
			CMD_QUERY: expected_reports.push_back(channel_report(c.channel, 0, 0, 1));
			CMD_CHECK: begin
				for (int i = 0; i < CHANNELS; i++) begin
					late  = 0;
					stuck = 0;
					if (reg_mask[i]) begin
						elapsed = wd_time - beat_time[i];
						late = elapsed > ch_timeout[i];
						if (per_mask[i])
							stuck = prog_count[i] == prog_snap[i];
						if (late || stuck) begin
							// the attempt count stops at its top before a possible clear
							if (attempt_cnt[i] != 8'hFF)
								attempt_cnt[i]++;
							if (c.recovery_ok_mask[i]) begin
								ch_health[i]   = HS_RUNNING;
								attempt_cnt[i] = '0;
							end else begin
								ch_health[i] = HS_DEGRADED;
								if (fault_cnt[i] != 16'hFFFF)
									fault_cnt[i]++;
							end
						end else begin
							ch_health[i] = HS_RUNNING;
						end
						prog_snap[i] = prog_count[i];
					end
					expected_reports.push_back(channel_report(i, late, stuck, i == CHANNELS - 1));
				end
			end
			default: ;  // spare codes are dropped
		endcase
	endfunction

	// ---------------------------------------------------------------
	// directed table helpers
	// ---------------------------------------------------------------
	function automatic stim_row_t op_row(logic [2:0] cmd, logic [1:0] ch, logic [3:0] ok);
		stim_row_t r;
		r.is_write = 0;
		r.reg_idx  = '0;
		r.reg_val  = '0;
		r.cmd      = '{command: cmd, channel: ch, recovery_ok_mask: ok};
		r.typed    = 0;
		r.want     = '0;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [2:0] idx, logic [15:0] val);
		stim_row_t r;
		r = op_row(CMD_TICK, 2'd0, 4'd0);
		r.is_write = 1;
		r.reg_idx  = idx;
		r.reg_val  = val;
		return r;
	endfunction

	// single-report command whose report is written out directly
	function automatic stim_row_t known_row(logic [2:0] cmd, logic [1:0] ch, health_t hs,
			logic [15:0] faults, logic [7:0] tries);
		stim_row_t r;
		r = op_row(cmd, ch, 4'd0);
		r.typed = 1;
		r.want  = '{report_channel: ch, health_state: hs, fault_total: faults,
			attempt_total: tries, timed_out: 1'b0, stalled: 1'b0, last: 1'b1};
		return r;
	endfunction

	function automatic cmd_item_t random_command();
		cmd_item_t c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c.channel          = 2'($urandom_range(0, 3));
		c.recovery_ok_mask = 4'($urandom_range(0, 15));
		if (roll < 28)      c.command = CMD_TICK;
		else if (roll < 44) c.command = CMD_BEAT;
		else if (roll < 58) c.command = CMD_PROG;
		else if (roll < 64) c.command = CMD_FAULT;
		else if (roll < 82) c.command = CMD_CHECK;
		else if (roll < 94) c.command = CMD_QUERY;
		else if (roll < 97) c.command = CMD_SPARE6;
		else                c.command = CMD_SPARE7;
		return c;
	endfunction

	// mostly short timeouts so that checks actually fire, now and then a wide one
	function automatic logic [15:0] random_timeout();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 6));
	endfunction

	task automatic log_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// command side
	// all tasks start and end on a rising edge
	// ---------------------------------------------------------------
	task automatic send_command(cmd_item_t c, bit typed, rpt_item_t want);
		cmd_bus.valid <= 1'b1;
		cmd_bus.data  <= c;
		do @(posedge clk); while (!cmd_bus.ready);
		predict_command(c);
		// a hand-written report stands in for the mirror's own
		if (typed) begin
			void'(expected_reports.pop_back());
			expected_reports.push_back(want);
		end
	endtask

	// random gap after a transfer; valid stays up when there is none
	task automatic sender_pause();
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 30);
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, let every owed report arrive, then let trailing
	// report-less commands leave the pipeline
	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write; only called while the unit is idle
	task automatic apply_setting(logic [2:0] idx, logic [15:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		case (idx)
			CFG_REGISTERED: reg_mask = val[3:0];
			CFG_PERIODIC:   per_mask = val[3:0];
			CFG_TIMEOUT0:   ch_timeout[0] = val;
			CFG_TIMEOUT1:   ch_timeout[1] = val;
			CFG_TIMEOUT2:   ch_timeout[2] = val;
			CFG_TIMEOUT3:   ch_timeout[3] = val;
			default: ;  // out-of-range index, dropped
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(logic [3:0] reg_m, logic [3:0] per_m, logic [15:0] t0,
			logic [15:0] t1, logic [15:0] t2, logic [15:0] t3);
		apply_setting(CFG_REGISTERED, {12'hABC, reg_m});
		apply_setting(CFG_PERIODIC, {12'h543, per_m});
		apply_setting(CFG_TIMEOUT0, t0);
		apply_setting(CFG_TIMEOUT1, t1);
		apply_setting(CFG_TIMEOUT2, t2);
		apply_setting(CFG_TIMEOUT3, t3);
	endtask

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		cmd_item_t c;
		int counted;

		arst_n        <= 1'b0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.data  <= '0;
		cfg_we        <= 1'b0;
		cfg_idx       <= '0;
		cfg_data      <= '0;
		steady        <= 1'b0;
		hold_request  <= 1'b0;

		// mirror at reset: nothing supervised, timeouts at their reset value
		reg_mask = '0;
		per_mask = '0;
		wd_time  = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			ch_timeout[i]  = TIMEOUT_RESET;
			beat_time[i]   = '0;
			prog_count[i]  = '0;
			prog_snap[i]   = '0;
			ch_health[i]   = HS_UNKNOWN;
			fault_cnt[i]   = '0;
			attempt_cnt[i] = '0;
		end

		directed_rows = '{
			// fresh state: unknown health, zero counts
			known_row(CMD_QUERY, 2'd0, HS_UNKNOWN, 16'd0, 8'd0),
			known_row(CMD_QUERY, 2'd3, HS_UNKNOWN, 16'd0, 8'd0),
			known_row(CMD_FAULT, 2'd3, HS_DEGRADED, 16'd1, 8'd0),
			// nothing registered yet: every channel reported as it stands
			op_row(CMD_CHECK, 2'd0, 4'hF),
			// spare codes must leave no trace
			op_row(CMD_SPARE6, 2'd1, 4'h0),
			op_row(CMD_SPARE7, 2'd2, 4'hF),
			known_row(CMD_QUERY, 2'd3, HS_DEGRADED, 16'd1, 8'd0),
			// writes past the last register must be dropped
			reg_row(CFG_SPARE6, 16'hFFFF),
			reg_row(CFG_SPARE7, 16'h0000),
			// upper data bits are ignored by the mask registers
			reg_row(CFG_REGISTERED, 16'hFFFF),
			reg_row(CFG_PERIODIC, 16'hFFF5),
			reg_row(CFG_TIMEOUT0, 16'h0000),
			reg_row(CFG_TIMEOUT1, 16'hFFFF),
			reg_row(CFG_TIMEOUT2, 16'd2),
			reg_row(CFG_TIMEOUT3, 16'd1),
			op_row(CMD_TICK, 2'd0, 4'h0),
			op_row(CMD_BEAT, 2'd1, 4'h0),
			op_row(CMD_PROG, 2'd0, 4'h0),
			op_row(CMD_TICK, 2'd3, 4'h0),
			op_row(CMD_TICK, 2'd2, 4'h0),
			// timeouts and a stall, half of them recovered
			op_row(CMD_CHECK, 2'd0, 4'b1010),
			op_row(CMD_CHECK, 2'd3, 4'hF),
			op_row(CMD_BEAT, 2'd2, 4'h0),
			op_row(CMD_PROG, 2'd2, 4'h0),
			op_row(CMD_CHECK, 2'd0, 4'h0),
			op_row(CMD_FAULT, 2'd0, 4'h0)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_write) begin
				wait_drained();
				apply_setting(directed_rows[k].reg_idx, directed_rows[k].reg_val);
			end else begin
				send_command(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);
				sender_pause();
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			case (p)
				0: load_settings(4'hF, 4'hF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				1: load_settings(4'hF, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: load_settings(4'hF, 4'($urandom_range(0, 15)), random_timeout(),
					random_timeout(), random_timeout(), random_timeout());
				default: load_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					random_timeout(), random_timeout(), random_timeout(), random_timeout());
			endcase
			steady <= (p == 1 || p == 4);
			// back-pressure: report side stalls long while commands keep coming
			if (p == 1)
				hold_request <= 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				c = random_command();
				send_command(c, 1'b0, '0);
				if (c.command <= CMD_QUERY)
					counted++;
				// one pause mid-phase until the unit has caught up
				if (p == 3 && counted == PHASE_ITEMS / 2)
					wait_drained();
				else
					sender_pause();
			end
		end

		// repeated failures: channel zero fails every check and never recovers,
		// then one successful recovery clears its attempt count
		wait_drained();
		load_settings(4'h1, 4'h0, 16'h0000, TIMEOUT_RESET, TIMEOUT_RESET, TIMEOUT_RESET);
		steady <= 1'b1;
		send_command('{command: CMD_TICK, channel: 2'd0, recovery_ok_mask: 4'h0}, 1'b0, '0);
		repeat (FAIL_CHECKS) begin
			c.command          = CMD_CHECK;
			c.channel          = 2'($urandom_range(0, 3));
			c.recovery_ok_mask = {3'($urandom_range(0, 7)), 1'b0};
			send_command(c, 1'b0, '0);
		end
		send_command('{command: CMD_CHECK, channel: 2'd0, recovery_ok_mask: 4'hF}, 1'b0, '0);
		send_command('{command: CMD_QUERY, channel: 2'd0, recovery_ok_mask: 4'h0}, 1'b0, '0);

		wait_drained();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------
	// report side: random stalls, one long hold on request
	// ---------------------------------------------------------------
	initial begin : report_sink
		int unsigned stall_left;
		stall_left = 0;
		rpt_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request <= 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left != 0) begin
				rpt_bus.ready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				// mostly short stalls, a few long ones
				rpt_bus.ready <= 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(0, 2);
			end else begin
				rpt_bus.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// report checker: every transfer against the oldest owed report
	// ---------------------------------------------------------------
	always @(posedge clk) begin : report_check
		rpt_item_t got;
		rpt_item_t want;
		if (arst_n && rpt_bus.valid && rpt_bus.ready) begin
			got = rpt_bus.data;
			if (expected_reports.size() == 0) begin
				log_mismatch("report with none owed, channel", got.report_channel, 0);
			end else begin
				want = expected_reports.pop_front();
				if (got.report_channel != want.report_channel)
					log_mismatch("report_channel", got.report_channel, want.report_channel);
				if (got.health_state != want.health_state)
					log_mismatch("health_state", got.health_state, want.health_state);
				if (got.fault_total != want.fault_total)
					log_mismatch("fault_total", got.fault_total, want.fault_total);
				if (got.attempt_total != want.attempt_total)
					log_mismatch("attempt_total", got.attempt_total, want.attempt_total);
				if (got.timed_out != want.timed_out)
					log_mismatch("timed_out", got.timed_out, want.timed_out);
				if (got.stalled != want.stalled)
					log_mismatch("stalled", got.stalled, want.stalled);
				if (got.last != want.last)
					log_mismatch("last", got.last, want.last);
			end
		end
	end

	// run guard: too long without a transfer on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (cmd_bus.valid && cmd_bus.ready) || (rpt_bus.valid && rpt_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

[sim.f]
rtl/mctw_pkg.sv
rtl/mctw_stream_if.sv
rtl/mctw_front.sv
rtl/mctw_back.sv
rtl/multi_channel_task_watchdog_unit.sv
tb/multi_channel_task_watchdog_unit_test.sv
